// ===== design/sfp_pkg.sv =====
package sfp_pkg;

  localparam int FRAME_BYTES   = 16;
  localparam int HEADER_BYTES  = 5;
  localparam int PAYLOAD_BYTES = FRAME_BYTES - HEADER_BYTES - 1;
  localparam int POS_W         = 6;
  localparam int PAY_IDX_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  localparam logic [1:0] STATUS_GOOD = 2'd0;
  localparam logic [1:0] STATUS_CSUM = 2'd1;
  localparam logic [1:0] STATUS_LEN  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_e;

  typedef struct packed {
    logic take;        // consume the byte on the input ports
    logic load_len;    // emit a wrong-length result
    logic load_csum;   // emit a checksum mismatch result
    logic load_first;  // emit payload word 0
    logic load_next;   // emit the payload word at the drain index
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_frame;
    logic at_csum;
    logic sum_ok;
    logic drain_last;
  } dp_stat_t;

endpackage

// ===== design/sfp_datapath.sv =====
module sfp_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfp_pkg::ctrl_cmd_t    cmd_i,
  output sfp_pkg::dp_stat_t     stat_o,
  input  logic [7:0]            rx_byte_i,
  input  logic                  frame_start_i,
  output logic                  strobe_o,
  output logic [1:0]            status_o,
  output logic [15:0]           target_id_o,
  output logic [15:0]           source_id_o,
  output logic [7:0]            command_code_o,
  output logic [7:0]            payload_byte_o,
  output logic [5:0]            payload_index_o,
  output logic                  last_result_o
);

  localparam logic [sfp_pkg::POS_W-1:0] PosCsum =
    sfp_pkg::POS_W'(sfp_pkg::FRAME_BYTES - 1);
  localparam logic [sfp_pkg::POS_W-1:0] PosPay =
    sfp_pkg::POS_W'(sfp_pkg::HEADER_BYTES);
  localparam logic [sfp_pkg::PAY_IDX_W-1:0] IdxLast =
    sfp_pkg::PAY_IDX_W'(sfp_pkg::PAYLOAD_BYTES - 1);

  logic [sfp_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [7:0]                    sum_q, sum_d;
  logic [15:0]                   target_q, source_q;
  logic [7:0]                    command_q;
  logic [7:0]                    store_q [sfp_pkg::PAYLOAD_BYTES];
  logic [sfp_pkg::PAY_IDX_W-1:0] idx_q;
  logic [sfp_pkg::POS_W-1:0]     pay_off;
  logic                          pay_wr;

  logic                          strobe_q;
  logic [1:0]                    status_q;
  logic [15:0]                   tgt_out_q, src_out_q;
  logic [7:0]                    cmd_out_q, pbyte_q;
  logic [5:0]                    pidx_q;
  logic                          last_q;

  assign pay_off = pos_q - PosPay;
  assign pay_wr  = cmd_i.take && !frame_start_i && (pos_q >= PosPay) && (pos_q < PosCsum);

  assign stat_o.in_frame   = (pos_q != '0);
  assign stat_o.at_csum    = (pos_q == PosCsum);
  assign stat_o.sum_ok     = (rx_byte_i == sum_q);
  assign stat_o.drain_last = (idx_q == IdxLast);

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (cmd_i.take) begin
      if (frame_start_i) begin
        pos_d = sfp_pkg::POS_W'(1);
        sum_d = rx_byte_i;
      end else if (pos_q == PosCsum) begin
        pos_d = '0;
      end else if (pos_q != '0) begin
        pos_d = pos_q + 1'b1;
        sum_d = sum_q + rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sum_q     <= '0;
      target_q  <= '0;
      source_q  <= '0;
      command_q <= '0;
      strobe_q  <= 1'b0;
      idx_q     <= '0;
    end else begin
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      strobe_q <= cmd_i.load_len || cmd_i.load_csum || cmd_i.load_first || cmd_i.load_next;
      if (cmd_i.take) begin
        if (frame_start_i) begin
          target_q <= {8'h00, rx_byte_i};
        end else begin
          unique case (pos_q)
            sfp_pkg::POS_W'(1): target_q  <= {rx_byte_i, target_q[7:0]};
            sfp_pkg::POS_W'(2): source_q  <= {8'h00, rx_byte_i};
            sfp_pkg::POS_W'(3): source_q  <= {rx_byte_i, source_q[7:0]};
            sfp_pkg::POS_W'(4): command_q <= rx_byte_i;
            default: ;
          endcase
        end
      end
      if (cmd_i.load_first) begin
        idx_q <= sfp_pkg::PAY_IDX_W'(1);
      end else if (cmd_i.load_next) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_wr) begin
      store_q[pay_off[sfp_pkg::PAY_IDX_W-1:0]] <= rx_byte_i;
    end
  end

  // result register: header fields come from the held values before this edge
  always_ff @(posedge clk_i) begin
    tgt_out_q <= target_q;
    src_out_q <= source_q;
    cmd_out_q <= command_q;
    if (cmd_i.load_len || cmd_i.load_csum) begin
      status_q <= cmd_i.load_len ? sfp_pkg::STATUS_LEN : sfp_pkg::STATUS_CSUM;
      pbyte_q  <= 8'h00;
      pidx_q   <= 6'd0;
      last_q   <= 1'b1;
    end else if (cmd_i.load_first) begin
      status_q <= sfp_pkg::STATUS_GOOD;
      pbyte_q  <= store_q[0];
      pidx_q   <= 6'd0;
      last_q   <= (sfp_pkg::PAYLOAD_BYTES == 1);
    end else if (cmd_i.load_next) begin
      status_q <= sfp_pkg::STATUS_GOOD;
      pbyte_q  <= store_q[idx_q];
      pidx_q   <= 6'(idx_q);
      last_q   <= (idx_q == IdxLast);
    end
  end

  assign strobe_o        = strobe_q;
  assign status_o        = status_q;
  assign target_id_o     = tgt_out_q;
  assign source_id_o     = src_out_q;
  assign command_code_o  = cmd_out_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_index_o = pidx_q;
  assign last_result_o   = last_q;

endmodule

// ===== design/sfp_ctrl.sv =====
module sfp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               frame_start_i,
  input  sfp_pkg::dp_stat_t  stat_i,
  output sfp_pkg::ctrl_cmd_t cmd_o,
  output logic               busy
);

  sfp_pkg::state_e state_q, state_d;
  logic            accept;
  logic            close;

  assign busy   = (state_q == sfp_pkg::S_DRAIN);
  assign accept = start && !busy;
  assign close  = accept && !frame_start_i && stat_i.at_csum;

  assign cmd_o.take       = accept;
  assign cmd_o.load_len   = accept && frame_start_i && stat_i.in_frame;
  assign cmd_o.load_csum  = close && !stat_i.sum_ok;
  assign cmd_o.load_first = close && stat_i.sum_ok;
  assign cmd_o.load_next  = busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfp_pkg::S_IDLE: begin
        if (cmd_o.load_first && (sfp_pkg::PAYLOAD_BYTES > 1)) begin
          state_d = sfp_pkg::S_DRAIN;
        end
      end
      sfp_pkg::S_DRAIN: begin
        // hold until the last payload word has been loaded
        if (stat_i.drain_last) begin
          state_d = sfp_pkg::S_IDLE;
        end
      end
      default: state_d = sfp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/sum_checked_frame_parser_top.sv =====
// Byte-sum checked frame parser.
// Input: one received byte per accepted word (rx_byte_i, frame_start_i), taken at
// a rising edge where start is high and busy is low. frame_start_i marks byte 0
// of a fixed-length frame: 2-byte target id, 2-byte source id, command byte,
// payload, then a checksum byte equal to the mod-256 sum of all bytes before it.
// Output: each result word is shown for one cycle with strobe_o high; the receiver
// cannot stall, so it must take every strobed word.
// Latency: an error word or payload word 0 is registered at the edge that takes the byte causing it.
// Throughput: one byte per cycle while a frame is collected. A good checksum
// starts the drain of the payload buffer through its single read port, one word a
// cycle; busy stays high after the checksum byte until the last payload word is
// loaded. A bad checksum gives one status 1 word, a start inside an open frame
// gives one status 2 word and reopens the frame; neither holds off the next byte.
// Bytes outside a frame are dropped.
// Reset: asynchronous, active low; clears position, running sum and header
// fields, leaves the block idle outside a frame.
module sum_checked_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        strobe_o,
  output logic [1:0]  status_o,
  output logic [15:0] target_id_o,
  output logic [15:0] source_id_o,
  output logic [7:0]  command_code_o,
  output logic [7:0]  payload_byte_o,
  output logic [5:0]  payload_index_o,
  output logic        last_result_o
);

  sfp_pkg::ctrl_cmd_t cmd;
  sfp_pkg::dp_stat_t  stat;

  sfp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .frame_start_i (frame_start_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .busy          (busy)
  );

  sfp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .rx_byte_i       (rx_byte_i),
    .frame_start_i   (frame_start_i),
    .strobe_o        (strobe_o),
    .status_o        (status_o),
    .target_id_o     (target_id_o),
    .source_id_o     (source_id_o),
    .command_code_o  (command_code_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .last_result_o   (last_result_o)
  );

endmodule

// ===== design/sfp_checker.sv =====
module sfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        strobe_o,
  input logic [1:0]  status_o,
  input logic [5:0]  payload_index_o,
  input logic        last_result_o
);

  // a non-final word is always followed by the next payload word
  a_drain_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_result_o |=> strobe_o && status_o == sfp_pkg::STATUS_GOOD)
    else $error("drain broke off before the last word");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_result_o |=> payload_index_o == $past(payload_index_o) + 6'd1)
    else $error("payload index did not advance by one");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o != sfp_pkg::STATUS_GOOD |-> last_result_o && payload_index_o == 6'd0)
    else $error("error word is not a single final word");

  a_busy_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> strobe_o)
    else $error("busy without a result word");

  a_first_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o == sfp_pkg::STATUS_GOOD && payload_index_o == 6'd0
      |-> $past(start && !busy))
    else $error("payload drain started without an accepted checksum byte");

endmodule

bind sum_checked_frame_parser_top sfp_checker u_sfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .strobe_o        (strobe_o),
  .status_o        (status_o),
  .payload_index_o (payload_index_o),
  .last_result_o   (last_result_o)
);

// ===== sim/tb_sum_checked_frame_parser_top.sv =====
module tb_sum_checked_frame_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 200;
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_WORDS = 120;
  localparam int CALM_AFTER   = 125;
  localparam int SETTLE_WAIT  = 20;

  typedef struct {
    logic [7:0] data;
    logic       sof;
    int         gap;
    bit         hold;
  } rx_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] target;
    logic [15:0] source;
    logic [7:0]  command;
    logic [7:0]  pbyte;
    logic [5:0]  pindex;
    logic        last;
  } frame_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [7:0]  rx_byte_i;
  logic        frame_start_i;
  logic        strobe_o;
  logic [1:0]  status_o;
  logic [15:0] target_id_o;
  logic [15:0] source_id_o;
  logic [7:0]  command_code_o;
  logic [7:0]  payload_byte_o;
  logic [5:0]  payload_index_o;
  logic        last_result_o;

  rx_word_t      rx_words_q[$];
  frame_result_t expected_results_q[$];

  int   fault_cnt;
  int   idle_cycles;
  int   words_queued;
  int   words_taken;
  int   gap_left;
  bit   bursty;
  logic word_taken;

  // deframer state as seen by the predictor
  logic [5:0]  frame_pos;
  logic [7:0]  frame_sum;
  logic [15:0] held_tgt;
  logic [15:0] held_src;
  logic [7:0]  held_cmd;
  logic [7:0]  held_payload [sfp_pkg::PAYLOAD_BYTES];

  sum_checked_frame_parser_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .rx_byte_i      (rx_byte_i),
    .frame_start_i  (frame_start_i),
    .strobe_o       (strobe_o),
    .status_o       (status_o),
    .target_id_o    (target_id_o),
    .source_id_o    (source_id_o),
    .command_code_o (command_code_o),
    .payload_byte_o (payload_byte_o),
    .payload_index_o(payload_index_o),
    .last_result_o  (last_result_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic push_result(input logic [1:0] status, input logic [7:0] pbyte,
                             input logic [5:0] pindex, input logic last);
    frame_result_t r;
    r.status  = status;
    r.target  = held_tgt;
    r.source  = held_src;
    r.command = held_cmd;
    r.pbyte   = pbyte;
    r.pindex  = pindex;
    r.last    = last;
    expected_results_q.insert(expected_results_q.size(), r);
  endtask

  task automatic parse_frame_byte(input logic [7:0] b, input logic sof);
    if (sof) begin
      // a start inside an open frame reports the wrong length first
      if (frame_pos != 6'd0) begin
        push_result(sfp_pkg::STATUS_LEN, 8'h00, 6'd0, 1'b1);
      end
      held_tgt  = {8'h00, b};
      frame_sum = b;
      frame_pos = 6'd1;
    end else if (frame_pos == 6'd0) begin
      // drop: outside a frame
    end else if (frame_pos < sfp_pkg::FRAME_BYTES - 1) begin
      case (frame_pos)
        6'd1:    held_tgt[15:8] = b;
        6'd2:    held_src = {8'h00, b};
        6'd3:    held_src[15:8] = b;
        6'd4:    held_cmd = b;
        default: held_payload[frame_pos - sfp_pkg::HEADER_BYTES] = b;
      endcase
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 6'd1;
    end else begin
      frame_pos = 6'd0;
      if (b != frame_sum) begin
        push_result(sfp_pkg::STATUS_CSUM, 8'h00, 6'd0, 1'b1);
      end else begin
        for (int i = 0; i < sfp_pkg::PAYLOAD_BYTES; i++) begin
          push_result(sfp_pkg::STATUS_GOOD, held_payload[i], i[5:0],
                      i == sfp_pkg::PAYLOAD_BYTES - 1);
        end
      end
    end
  endtask

  task automatic report_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= MAX_SHOWN) begin
      $display("%s", msg);
    end
  endtask

  task automatic queue_word(input logic [7:0] data, input logic sof, input bit hold);
    rx_word_t w;
    w.data = data;
    w.sof  = sof;
    w.hold = hold && words_queued < CALM_AFTER;
    w.gap  = 0;
    if (bursty && words_queued < CALM_AFTER && $urandom_range(0, 3) == 0) begin
      w.gap = $urandom_range(1, 17);
    end
    rx_words_q.insert(rx_words_q.size(), w);
    words_queued++;
  endtask

  // Queue the first n_bytes of a frame; extreme_pay alternates 00 and FF.
  task automatic queue_frame(input logic [15:0] tgt, input logic [15:0] src,
                             input logic [7:0] cmd, input bit extreme_pay,
                             input int n_bytes, input bit bad_sum, input bit hold);
    logic [7:0] fb [sfp_pkg::FRAME_BYTES];
    logic [7:0] sum;
    fb[0] = tgt[7:0];
    fb[1] = tgt[15:8];
    fb[2] = src[7:0];
    fb[3] = src[15:8];
    fb[4] = cmd;
    for (int i = 0; i < sfp_pkg::PAYLOAD_BYTES; i++) begin
      fb[sfp_pkg::HEADER_BYTES + i] = extreme_pay ? ((i % 2) ? 8'hFF : 8'h00)
                                                  : 8'($urandom);
    end
    sum = 8'h00;
    for (int i = 0; i < sfp_pkg::FRAME_BYTES - 1; i++) begin
      sum = sum + fb[i];
    end
    fb[sfp_pkg::FRAME_BYTES - 1] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
    for (int k = 0; k < n_bytes; k++) begin
      queue_word(fb[k], k == 0, hold && k == 0);
    end
  endtask

  // Driver: present words at the falling edge, hold until taken.
  always @(negedge clk_i) begin
    rx_word_t w;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (rx_words_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        w = rx_words_q[0];
        if (w.hold && expected_results_q.size() != 0) begin
          start <= 1'b0;
        end else if (w.gap > 0) begin
          gap_left = w.gap - 1;
          w.gap = 0;
          rx_words_q[0] = w;
          start <= 1'b0;
        end else begin
          void'(rx_words_q.pop_front());
          start         <= 1'b1;
          rx_byte_i     <= w.data;
          frame_start_i <= w.sof;
        end
      end
    end
  end

  // Monitor: check strobed results, then predict from the accepted word.
  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= start && !busy;
      if (strobe_o) begin
        got = {status_o, target_id_o, source_id_o, command_code_o,
               payload_byte_o, payload_index_o, last_result_o};
        if (expected_results_q.size() == 0) begin
          report_fault($sformatf("unexpected result: status %0d target %h source %h cmd %h",
                                 got.status, got.target, got.source, got.command));
        end else begin
          want = expected_results_q.pop_front();
          if (got.status !== want.status || got.target !== want.target ||
              got.source !== want.source || got.command !== want.command ||
              got.pbyte !== want.pbyte || got.pindex !== want.pindex ||
              got.last !== want.last) begin
            report_fault($sformatf(
              "mismatch exp/got: status %0d/%0d tgt %h/%h src %h/%h cmd %h/%h %s",
              want.status, got.status, want.target, got.target, want.source, got.source,
              want.command, got.command,
              $sformatf("byte %h/%h idx %0d/%0d last %0b/%0b", want.pbyte, got.pbyte,
                        want.pindex, got.pindex, want.last, got.last)));
          end
        end
      end
      if (start && !busy) begin
        parse_frame_byte(rx_byte_i, frame_start_i);
        words_taken++;
      end
      if (strobe_o || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int random_cnt;
    int kind;
    int n_bytes;
    bit first;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    rx_byte_i     = 8'h00;
    frame_start_i = 1'b0;
    fault_cnt     = 0;
    idle_cycles   = 0;
    words_queued  = 0;
    words_taken   = 0;
    gap_left      = 0;
    bursty        = 1'b1;
    frame_pos     = 6'd0;
    frame_sum     = 8'h00;
    held_tgt      = 16'h0000;
    held_src      = 16'h0000;
    held_cmd      = 8'h00;
    random_cnt    = 0;
    first         = 1'b1;

    // directed: stray bytes, a cut-off frame, then a good frame of extremes
    queue_word(8'hFF, 1'b0, 1'b0);
    queue_word(8'h00, 1'b0, 1'b0);
    queue_frame(16'hFFFF, 16'h0000, 8'hFF, 1'b1, 3, 1'b0, 1'b0);
    queue_frame(16'h0000, 16'hFFFF, 8'h00, 1'b1, sfp_pkg::FRAME_BYTES, 1'b0, 1'b0);

    while (random_cnt < RANDOM_WORDS) begin
      bursty = $urandom_range(0, 2) != 0;
      kind   = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 3)) queue_word(8'($urandom), 1'b0, 1'b0);
      end else begin
        n_bytes = (kind == 1) ? $urandom_range(1, sfp_pkg::FRAME_BYTES - 1)
                              : sfp_pkg::FRAME_BYTES;
        queue_frame(16'($urandom), 16'($urandom), 8'($urandom), $urandom_range(0, 5) == 0,
                    n_bytes, first || kind <= 3, first || $urandom_range(0, 3) == 0);
        random_cnt += n_bytes;
        first = 1'b0;
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (words_taken != words_queued || expected_results_q.size() != 0);
    repeat (SETTLE_WAIT) @(negedge clk_i);

    if (fault_cnt == 0 && expected_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sfp_pkg.sv
design/sfp_datapath.sv
design/sfp_ctrl.sv
design/sum_checked_frame_parser_top.sv
design/sfp_checker.sv
sim/tb_sum_checked_frame_parser_top.sv
